FILE: rtl/pld_pkg.sv
// Shared types and constants of the PalmDoc LZ77 decoder.
package pld_pkg;

  localparam int HistDepth  = 2048;
  localparam int HistAw     = $clog2(HistDepth);
  localparam int QueueDepth = 4;
  localparam int CountW     = 16;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] XOR_MASK   = 8'h80;
  localparam logic [7:0] PAIR_MIN   = 8'h80;
  localparam logic [7:0] SPACE_MIN  = 8'hC0;
  localparam logic [7:0] LIT_MIN    = 8'h09;
  localparam logic [7:0] LIT_ZERO   = 8'h00;
  localparam logic [3:0] SPAN_BASE  = 4'd3;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // Result error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIST  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Work passed from the parser to the output engine.
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_LIT   = 3'd1,
    K_SPACE = 3'd2,
    K_COPY  = 3'd3,
    K_BAD   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [3:0]        span;
    logic [HistAw-1:0] distance;
    logic              trunc;
    logic              last;
  } cmd_t;

  // Saturating add of a small amount to the byte count.
  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [3:0] b);
    logic [CountW:0] sum;
    sum = {1'b0, a} + {{(CountW-3){1'b0}}, b};
    return sum[CountW] ? COUNT_MAX : sum[CountW-1:0];
  endfunction

endpackage

FILE: rtl/palmdoc_lz77_decoder.sv
// Top level of the PalmDoc LZ77 record decoder.
// The decoder takes one compressed byte per transaction on s_axis and returns
// the decoded bytes on m_axis, one per transaction. A parser accepts a byte in
// every cycle while its four-entry work queue has room; it tracks the token
// phase and the bytes scheduled so far, so it checks copy distances itself.
// The output engine drains the queue: it takes a work entry, then emits each
// literal or expanded byte, and for each copied byte reads the 2048-byte
// history memory, then emits the byte and writes it into the history. tlast
// on m_axis marks the last result of one input byte; tuser carries the error
// code (1 bad copy distance, 2 token cut off at record end), in which case the
// data byte is zero. An s_axis tlast ends the record and clears the parser,
// history pointer and byte count.
module palmdoc_lz77_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] decoded_count
  output logic [1:0]  m_axis_tuser,   // [1:0] error_code
  output logic        m_axis_tlast    // run_last
);

  pld_pkg::cmd_t push_cmd, head;
  logic          push, pop, full, empty;
  logic [7:0]    out_byte;
  logic [15:0]   decoded_count;

  // Parse tokens and queue work.
  pld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  // Decouple parser and output engine so each can stall on its own.
  pld_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Emit bytes through the output register.
  pld_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (empty),
    .q_head        (head),
    .q_pop         (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (out_byte),
    .run_last      (m_axis_tlast),
    .error_code    (m_axis_tuser),
    .decoded_count (decoded_count)
  );

  assign m_axis_tdata = {decoded_count, out_byte};

endmodule

FILE: rtl/pld_front.sv
// Token parser: classifies compressed bytes and queues work for the output engine.
module pld_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output pld_pkg::cmd_t     q_cmd
);

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_RAW  = 3'b010,
    P_PAIR = 3'b100
  } phase_t;

  phase_t                      phase, phase_next;
  logic [3:0]                  raw_rem, raw_rem_next;
  logic [7:0]                  pair_first, pair_first_next;
  logic [pld_pkg::CountW-1:0]  count, count_next;
  logic [15:0]                 word;
  logic [3:0]                  span;
  logic [pld_pkg::HistAw-1:0]  back;
  logic [3:0]                  rem_dec;
  logic                        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign word     = {pair_first, in_byte};
  assign span     = pld_pkg::SPAN_BASE + {1'b0, word[2:0]};
  assign back     = word[13:3];
  assign rem_dec  = (raw_rem != 4'd0) ? raw_rem - 4'd1 : 4'd0;

  always_comb begin
    phase_next      = phase;
    raw_rem_next    = raw_rem;
    pair_first_next = pair_first;
    count_next      = count;
    q_cmd.kind      = pld_pkg::K_NONE;
    q_cmd.data      = in_byte;
    q_cmd.span      = span;
    q_cmd.distance  = back;
    q_cmd.trunc     = 1'b0;
    q_cmd.last      = in_last;
    case (phase)
      P_RAW: begin
        q_cmd.kind   = pld_pkg::K_LIT;
        count_next   = pld_pkg::sat_add(count, 4'd1);
        raw_rem_next = rem_dec;
        if (rem_dec == 4'd0) begin
          phase_next = P_IDLE;
        end else begin
          q_cmd.trunc = in_last;
        end
      end
      P_PAIR: begin
        phase_next = P_IDLE;
        if (back == '0 || {{(pld_pkg::CountW-pld_pkg::HistAw){1'b0}}, back} > count) begin
          q_cmd.kind = pld_pkg::K_BAD;
        end else begin
          q_cmd.kind = pld_pkg::K_COPY;
          count_next = pld_pkg::sat_add(count, span);
        end
      end
      default: begin
        if (in_byte >= pld_pkg::SPACE_MIN) begin
          q_cmd.kind = pld_pkg::K_SPACE;
          count_next = pld_pkg::sat_add(count, 4'd2);
        end else if (in_byte >= pld_pkg::PAIR_MIN) begin
          pair_first_next = in_byte;
          phase_next      = P_PAIR;
          q_cmd.trunc     = in_last;
        end else if (in_byte >= pld_pkg::LIT_MIN || in_byte == pld_pkg::LIT_ZERO) begin
          q_cmd.kind = pld_pkg::K_LIT;
          count_next = pld_pkg::sat_add(count, 4'd1);
        end else begin
          raw_rem_next = in_byte[3:0];
          phase_next   = P_RAW;
          q_cmd.trunc  = in_last;
        end
      end
    endcase
    // End of record: return the parser to its reset state.
    if (in_last) begin
      phase_next      = P_IDLE;
      raw_rem_next    = 4'd0;
      pair_first_next = 8'd0;
      count_next      = '0;
    end
  end

  assign q_push = accept && (q_cmd.kind != pld_pkg::K_NONE || q_cmd.trunc);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      raw_rem    <= 4'd0;
      pair_first <= 8'd0;
      count      <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      raw_rem    <= raw_rem_next;
      pair_first <= pair_first_next;
      count      <= count_next;
    end
  end

endmodule

FILE: rtl/pld_cmd_fifo.sv
// Small work queue between the token parser and the output engine.
module pld_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pld_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output pld_pkg::cmd_t head,
  output logic          empty
);

  localparam int Aw = $clog2(pld_pkg::QueueDepth);

  pld_pkg::cmd_t store [pld_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0]   fill;

  assign full  = (fill == (Aw+1)'(pld_pkg::QueueDepth));
  assign empty = (fill == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Aw'(pld_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Aw'(pld_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/pld_back.sv
// Output engine: emits decoded bytes, runs copies through the history memory.
module pld_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  pld_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       run_last,
  output logic [1:0]                 error_code,
  output logic [pld_pkg::CountW-1:0] decoded_count
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_READ  = 4'b0010,
    B_EMIT  = 4'b0100,
    B_TRUNC = 4'b1000
  } bstate_t;

  bstate_t                     state, state_next;
  pld_pkg::cmd_t               cmd;
  logic [3:0]                  step, step_next;
  logic [pld_pkg::HistAw-1:0]  hptr, hptr_next;
  logic [pld_pkg::CountW-1:0]  count, count_next, count_inc;
  logic [7:0]                  hist [pld_pkg::HistDepth];
  logic [7:0]                  rd_data;
  logic [pld_pkg::HistAw-1:0]  rd_addr;
  logic                        rd_en, mem_we;
  logic [7:0]                  val;
  logic [3:0]                  n_main;
  logic                        final_main;
  logic                        can_load, load;
  logic [7:0]                  res_byte;
  logic                        res_last;
  logic [1:0]                  res_err;
  logic [pld_pkg::CountW-1:0]  res_count;

  assign can_load  = !out_valid || out_ready;
  assign rd_addr   = hptr - cmd.distance;
  assign count_inc = pld_pkg::sat_add(count, 4'd1);

  always_comb begin
    case (cmd.kind)
      pld_pkg::K_SPACE: n_main = 4'd2;
      pld_pkg::K_COPY:  n_main = cmd.span;
      pld_pkg::K_LIT,
      pld_pkg::K_BAD:   n_main = 4'd1;
      default:          n_main = 4'd0;
    endcase
  end
  assign final_main = (step == n_main - 4'd1);

  always_comb begin
    case (cmd.kind)
      pld_pkg::K_LIT:   val = cmd.data;
      pld_pkg::K_SPACE: val = (step == 4'd0) ? pld_pkg::SPACE_CHAR
                                             : cmd.data ^ pld_pkg::XOR_MASK;
      pld_pkg::K_COPY:  val = rd_data;
      default:          val = 8'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    hptr_next  = hptr;
    count_next = count;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    res_byte   = val;
    res_err    = pld_pkg::ERR_NONE;
    res_last   = 1'b0;
    res_count  = count;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          step_next = 4'd0;
          if (q_head.kind == pld_pkg::K_COPY) begin
            state_next = B_READ;
          end else if (q_head.kind == pld_pkg::K_NONE) begin
            state_next = B_TRUNC;
          end else begin
            state_next = B_EMIT;
          end
        end
      end
      B_READ: begin
        rd_en      = 1'b1;
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (can_load) begin
          load = 1'b1;
          if (cmd.kind == pld_pkg::K_BAD) begin
            res_err = pld_pkg::ERR_DIST;
          end else begin
            mem_we     = 1'b1;
            hptr_next  = hptr + 1'b1;
            count_next = count_inc;
            res_count  = count_inc;
          end
          res_last = final_main && !cmd.trunc;
          if (!final_main) begin
            step_next  = step + 4'd1;
            state_next = (cmd.kind == pld_pkg::K_COPY) ? B_READ : B_EMIT;
          end else if (cmd.trunc) begin
            state_next = B_TRUNC;
          end else begin
            state_next = B_IDLE;
            if (cmd.last) begin
              hptr_next  = '0;
              count_next = '0;
            end
          end
        end
      end
      B_TRUNC: begin
        if (can_load) begin
          load       = 1'b1;
          res_byte   = 8'd0;
          res_err    = pld_pkg::ERR_TRUNC;
          res_last   = 1'b1;
          state_next = B_IDLE;
          if (cmd.last) begin
            hptr_next  = '0;
            count_next = '0;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[hptr] <= val;
    end
    if (rd_en) begin
      rd_data <= hist[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (load) begin
      out_byte      <= res_byte;
      run_last      <= res_last;
      error_code    <= res_err;
      decoded_count <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= 4'd0;
      hptr      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      hptr      <= hptr_next;
      count     <= count_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the PalmDoc LZ77 record decoder.
module tb;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 40;
  localparam int MAX_DIST = pld_pkg::HistDepth - 1;

  typedef enum logic [1:0] {PH_IDLE, PH_RAW, PH_PAIR} parse_ph_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // One compressed byte waiting to be offered; drain holds it back until
  // every decoded byte predicted so far has come out.
  typedef struct {
    logic [7:0] code;
    logic       last;
    bit         drain;
  } comp_item_t;

  typedef struct {
    logic [7:0]                 data;
    logic                       run_last;
    logic [1:0]                 err;
    logic [pld_pkg::CountW-1:0] count;
  } dec_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  palmdoc_lz77_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  comp_item_t code_queue[$];
  dec_out_t   decoded_due[$];
  dec_out_t   step_res[$];

  // Decoder shadow state.
  parse_ph_t                  phase = PH_IDLE;
  logic [3:0]                 raw_left = '0;
  logic [7:0]                 pair_hi = '0;
  logic [7:0]                 hist [pld_pkg::HistDepth];
  logic [pld_pkg::HistAw-1:0] hptr = '0;
  logic [pld_pkg::CountW-1:0] nbytes = '0;

  int  n_bad = 0;
  int  n_taken = 0;
  int  hold_at = 0;
  int  cycles = 0;
  bit  offer = 0;
  bit  hold_rx = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int  rx_left = 0;
  int  rx_tick = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_bad++;
    if (n_bad <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic dec_out_t make_res(input logic [7:0] data, input logic [1:0] err);
    dec_out_t r;
    r.data = data;
    r.run_last = 1'b0;
    r.err = err;
    r.count = nbytes;
    return r;
  endfunction

  // Append one decoded byte to the history and count it.
  task automatic store_byte(input logic [7:0] b);
    hist[hptr] = b;
    hptr = hptr + 1'b1;
    if (nbytes != pld_pkg::COUNT_MAX)
      nbytes = nbytes + 1'b1;
    step_res.push_back(make_res(b, pld_pkg::ERR_NONE));
  endtask

  task automatic decode_code(input logic [7:0] code, input logic last_in);
    bit                         cut;
    logic [15:0]                word;
    logic [3:0]                 span;
    logic [pld_pkg::HistAw-1:0] back;
    logic [pld_pkg::HistAw-1:0] src;
    cut = 0;
    step_res.delete();
    case (phase)
      PH_RAW: begin
        store_byte(code);
        if (raw_left != 0)
          raw_left = raw_left - 1'b1;
        if (raw_left == 0)
          phase = PH_IDLE;
        else if (last_in)
          cut = 1;
      end
      PH_PAIR: begin
        word = {pair_hi, code};
        span = pld_pkg::SPAN_BASE + {1'b0, word[2:0]};
        back = word[13:3];
        phase = PH_IDLE;
        if (back == 0 || pld_pkg::CountW'(back) > nbytes) begin
          step_res.push_back(make_res(8'h00, pld_pkg::ERR_DIST));
        end else begin
          // Byte by byte, so an overlapping copy repeats fresh output.
          for (int k = 0; k < span; k++) begin
            src = hptr - back;
            store_byte(hist[src]);
          end
        end
      end
      default: begin
        if (code >= pld_pkg::SPACE_MIN) begin
          store_byte(pld_pkg::SPACE_CHAR);
          store_byte(code ^ pld_pkg::XOR_MASK);
        end else if (code >= pld_pkg::PAIR_MIN) begin
          pair_hi = code;
          phase = PH_PAIR;
          if (last_in)
            cut = 1;
        end else if (code >= pld_pkg::LIT_MIN || code == pld_pkg::LIT_ZERO) begin
          store_byte(code);
        end else begin
          raw_left = code[3:0];
          phase = PH_RAW;
          if (last_in)
            cut = 1;
        end
      end
    endcase
    if (cut)
      step_res.push_back(make_res(8'h00, pld_pkg::ERR_TRUNC));
    if (step_res.size() > 0)
      step_res[step_res.size() - 1].run_last = 1'b1;
    foreach (step_res[i])
      decoded_due.push_back(step_res[i]);
    // End of record: history contents stay but become unreachable.
    if (last_in) begin
      phase = PH_IDLE;
      raw_left = '0;
      pair_hi = '0;
      hptr = '0;
      nbytes = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic push_code(input logic [7:0] code, input logic last, input bit drain = 0);
    comp_item_t it;
    it.code = code;
    it.last = last;
    it.drain = drain;
    code_queue.push_back(it);
  endtask

  task automatic push_pair(input int back, input int span, input bit drain = 0);
    logic [pld_pkg::HistAw-1:0] d;
    logic [2:0]                 s;
    d = back[pld_pkg::HistAw-1:0];
    s = 3'(span - pld_pkg::SPAN_BASE);
    push_code(pld_pkg::PAIR_MIN | {2'b00, d[10:5]}, 1'b0, drain);
    push_code({d[4:0], s}, 1'b0);
  endtask

  function automatic int dist_limit(input int made);
    return (made > MAX_DIST) ? MAX_DIST : made;
  endfunction

  // A record of random tokens, some with bad copy distances, sometimes cut off at the end.
  task automatic gen_record(input int n_tok, input bit drain);
    int made;
    int n;
    int back;
    bit first;
    made = 0;
    first = drain;
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 7) == 0)
            push_code(pld_pkg::LIT_ZERO, 1'b0, first);
          else
            push_code(8'($urandom_range(pld_pkg::LIT_MIN, pld_pkg::PAIR_MIN - 1)), 1'b0,
                      first);
          made += 1;
        end
        3: begin
          push_code(8'($urandom_range(pld_pkg::SPACE_MIN, 255)), 1'b0, first);
          made += 2;
        end
        4, 5: begin
          n = $urandom_range(1, 8);
          push_code(8'(n), 1'b0, first);
          for (int i = 0; i < n; i++)
            push_code(8'($urandom_range(0, 255)), 1'b0);
          made += n;
        end
        6, 7, 8: begin
          if (made == 0) begin
            push_code(8'($urandom_range(pld_pkg::LIT_MIN, pld_pkg::PAIR_MIN - 1)), 1'b0,
                      first);
            made += 1;
          end else begin
            n = $urandom_range(3, 10);
            push_pair($urandom_range(1, dist_limit(made)), n, first);
            made += n;
          end
        end
        default: begin
          // Zero distance or one reaching past the record start.
          if (made >= MAX_DIST || $urandom_range(0, 1) == 0)
            back = 0;
          else
            back = $urandom_range(made + 1, MAX_DIST);
          push_pair(back, $urandom_range(3, 10), first);
        end
      endcase
      first = 0;
    end
    case ($urandom_range(0, 5))
      0: push_code(8'($urandom_range(pld_pkg::PAIR_MIN, pld_pkg::SPACE_MIN - 1)), 1'b1);
      1: push_code(8'($urandom_range(1, pld_pkg::LIT_MIN - 1)), 1'b1);
      2: begin
        n = $urandom_range(2, 8);
        push_code(8'(n), 1'b0);
        for (int i = 1; i < n; i++)
          push_code(8'($urandom_range(0, 255)), i == n - 1);
      end
      default: code_queue[code_queue.size() - 1].last = 1'b1;
    endcase
  endtask

  // Unstructured bytes with stray record ends.
  task automatic gen_noise(input int n);
    for (int i = 0; i < n; i++)
      push_code(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: accept at the rising edge, drive at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      decode_code(s_axis_tdata, s_axis_tlast);
      code_queue.delete(0);
      offer = 0;
      n_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!offer) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (code_queue.size() == 0 ||
                   (code_queue[0].drain && decoded_due.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata <= code_queue[0].code;
        s_axis_tlast <= code_queue[0].last;
        s_axis_tvalid <= 1'b1;
        offer = 1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bit ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   ready = 1;
        RX_COIN:   ready = $urandom_range(0, 1);
        RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
        default:   ready = (rx_tick % 5) < 3;
      endcase
      m_axis_tready <= ready && !hold_rx;
    end
  end

  // Hold the output off long enough for the decoder to back up into s_axis.
  initial begin
    wait (hold_at != 0 && n_taken >= hold_at);
    hold_rx = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 0;
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dec_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_due.size() == 0) begin
        flag_mismatch("unexpected result, data", m_axis_tdata, 0);
      end else begin
        want = decoded_due.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          flag_mismatch("out_byte", m_axis_tdata[7:0], want.data);
        if (m_axis_tlast !== want.run_last)
          flag_mismatch("run_last", m_axis_tlast, want.run_last);
        if (m_axis_tuser !== want.err)
          flag_mismatch("error_code", m_axis_tuser, want.err);
        if (m_axis_tdata[23:8] !== want.count)
          flag_mismatch("decoded_count", m_axis_tdata[23:8], want.count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand_start;
    // Literals at both ends of their ranges and the space expansion.
    push_code(8'h00, 1'b0);
    push_code(8'h09, 1'b0);
    push_code(8'h7F, 1'b0);
    push_code(8'hC0, 1'b0);
    push_code(8'hFF, 1'b0);
    // Overlapping copy at distance one, then zero and too-far distances.
    push_pair(1, 6);
    push_pair(0, 3);
    push_pair(MAX_DIST, 10);
    // Longest copy, reaching seven bytes back.
    push_pair(7, 10);
    // Raw runs: one of two bytes, and the longest cut off by the record end.
    push_code(8'd2, 1'b0);
    push_code(8'h85, 1'b0);
    push_code(8'h01, 1'b0);
    push_code(8'd8, 1'b0);
    push_code(8'hAA, 1'b0);
    push_code(8'h55, 1'b1);
    // Records ending on a pair start, on a raw count and on a literal zero.
    push_code(8'h80, 1'b1);
    push_code(8'd3, 1'b1);
    push_code(8'h00, 1'b1);
    hold_at = code_queue.size() + 40;

    n_rand_start = code_queue.size();
    gen_record($urandom_range(4, 12), 1'b1);
    while (code_queue.size() - n_rand_start < 160) begin
      if ($urandom_range(0, 5) == 0)
        gen_noise($urandom_range(1, 10));
      else
        gen_record($urandom_range(1, 12), 1'b0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (code_queue.size() == 0 && !offer);
    wait (decoded_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_bad == 0 && decoded_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (decoded_due.size() != 0)
        flag_mismatch("results left over", decoded_due.size(), 0);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: palmdoc_lz77_decoder.f
rtl/pld_pkg.sv
rtl/pld_front.sv
rtl/pld_cmd_fifo.sv
rtl/pld_back.sv
rtl/palmdoc_lz77_decoder.sv
verif/tb.sv
